>>> src/swidc_pkg.sv
// Shared types and constants for the sliding window idle source counter.
`timescale 1ns / 1ps

package swidc_pkg;

    localparam int MAX_SOURCES_DEF = 1024;
    localparam int FIFO_DEPTH_DEF  = 1024;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int ID_W       = 11;
    localparam int TS_W       = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ID_W-1:0]       SC_RESET  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] WIN_RESET = 32'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 1'd1;

    localparam logic CMD_LOG   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] source_id;
        logic [TS_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] idle_sources;
        logic            overflow_seen;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;     // zero one count entry during the clearing pass
        logic log_start;  // push request into FIFO, fetch its count
        logic log_drop;   // FIFO full: flag overflow
        logic log_upd;    // write back incremented count
        logic q_start;    // latch query time, fetch FIFO head
        logic ev_read;    // fetch FIFO head
        logic ev_pop;     // pop head, fetch its count
        logic ev_upd;     // write back decremented count
        logic out_load;   // load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic id_ok;
        logic fifo_full;
        logic fifo_empty;
        logic evict;
        logic out_free;
    } t_status;

endpackage

>>> src/swidc_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module swidc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/swidc_ctrl.sv
// Controller: sequences clearing, logging, eviction and result hand-off.
`timescale 1ns / 1ps

module swidc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_command,
    output logic               o_in_ready,
    input  swidc_pkg::t_status i_status,
    output swidc_pkg::t_cmd    o_cmd
);
    import swidc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOG    = 6'b000100,
        S_EV_CHK = 6'b001000,
        S_EV_UPD = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_in_command == CMD_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_state = i_status.fifo_empty ? S_RESULT : S_EV_CHK;
                    end else if (i_status.id_ok) begin
                        if (i_status.fifo_full) begin
                            o_cmd.log_drop = 1'b1;
                        end else begin
                            o_cmd.log_start = 1'b1;
                            n_state = S_LOG;
                        end
                    end
                end
            end
            S_LOG: begin
                o_cmd.log_upd = 1'b1;
                n_state = S_IDLE;
            end
            S_EV_CHK: begin
                if (i_status.evict) begin
                    o_cmd.ev_pop = 1'b1;
                    n_state = S_EV_UPD;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_EV_UPD: begin
                o_cmd.ev_upd = 1'b1;
                if (i_status.fifo_empty) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.ev_read = 1'b1;
                    n_state = S_EV_CHK;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/swidc_dp.sv
// Datapath: config registers, event FIFO, per-source counts, result register.
`timescale 1ns / 1ps

module swidc_dp #(
    parameter int MAX_SOURCES = swidc_pkg::MAX_SOURCES_DEF,
    parameter int FIFO_DEPTH  = swidc_pkg::FIFO_DEPTH_DEF,
    parameter int TIME_WIDTH  = swidc_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [swidc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swidc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  swidc_pkg::t_in_item                  i_in,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output swidc_pkg::t_out_item                 o_out,
    input  swidc_pkg::t_cmd                      i_cmd,
    output swidc_pkg::t_status                   o_status
);
    import swidc_pkg::*;

    localparam int SW    = $clog2(MAX_SOURCES + 1);   // source index / active total
    localparam int AW    = $clog2(FIFO_DEPTH);        // FIFO pointer
    localparam int FW    = $clog2(FIFO_DEPTH + 1);    // FIFO fill and count width
    localparam int TW    = TIME_WIDTH;
    localparam int EW    = SW + TW;                   // FIFO entry
    localparam int MW    = (SW > ID_W) ? SW : ID_W;
    localparam int CMP_W = (TW > CFG_DATA_W) ? TW : CFG_DATA_W;

    logic [ID_W-1:0]       r_server_count;
    logic [CFG_DATA_W-1:0] r_window;

    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [FW-1:0] r_fill;
    logic [SW-1:0] r_active;
    logic          r_overflow;
    logic [SW-1:0] r_clr_cnt;
    logic [TW-1:0] r_q;
    logic [SW-1:0] r_id;
    logic [SW-1:0] r_src;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [EW-1:0] fifo_rdata;
    logic [EW-1:0] fifo_wdata;
    logic [SW-1:0] head_src;
    logic [TW-1:0] head_time;
    logic [TW-1:0] head_age;

    logic          hits_we;
    logic [SW-1:0] hits_waddr;
    logic [FW-1:0] hits_wdata;
    logic          hits_re;
    logic [SW-1:0] hits_raddr;
    logic [FW-1:0] hits_rdata;

    logic [MW-1:0] in_id_w;
    logic [MW-1:0] sc_w;
    logic [MW-1:0] act_w;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] head_inc;

    assign in_id_w = MW'(i_in.source_id);
    assign sc_w    = MW'(r_server_count);
    assign act_w   = MW'(r_active);

    assign tail_inc = (r_tail == AW'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign head_inc = (r_head == AW'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign fifo_wdata = {SW'(i_in.source_id), TW'(i_in.timestamp)};
    assign head_src   = fifo_rdata[EW-1:TW];
    assign head_time  = fifo_rdata[TW-1:0];
    assign head_age   = r_q - head_time;

    swidc_ram #(
        .WIDTH(EW),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.log_start),
        .i_waddr(r_tail),
        .i_wdata(fifo_wdata),
        .i_re   (i_cmd.q_start || i_cmd.ev_read),
        .i_raddr(r_head),
        .o_rdata(fifo_rdata)
    );

    // count write port: clearing pass, log increment or eviction decrement
    always_comb begin
        hits_we    = i_cmd.clr_wr || i_cmd.log_upd || i_cmd.ev_upd;
        hits_waddr = r_clr_cnt;
        hits_wdata = '0;
        if (i_cmd.log_upd) begin
            hits_waddr = r_id;
            hits_wdata = hits_rdata + 1'b1;
        end else if (i_cmd.ev_upd) begin
            hits_waddr = r_src;
            hits_wdata = hits_rdata - FW'(hits_rdata != '0);
        end
    end

    assign hits_re    = i_cmd.log_start || i_cmd.ev_pop;
    assign hits_raddr = i_cmd.ev_pop ? head_src : SW'(i_in.source_id);

    swidc_ram #(
        .WIDTH(FW),
        .DEPTH(MAX_SOURCES + 1)
    ) u_hits_ram (
        .i_clk  (i_clk),
        .i_we   (hits_we),
        .i_waddr(hits_waddr),
        .i_wdata(hits_wdata),
        .i_re   (hits_re),
        .i_raddr(hits_raddr),
        .o_rdata(hits_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= SC_RESET;
            r_window       <= WIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SERVER_COUNT: r_server_count <= i_cfg_data[ID_W-1:0];
                CFG_WINDOW:       r_window       <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_active    <= '0;
            r_overflow  <= 1'b0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.log_drop) begin
                r_overflow <= 1'b1;
            end
            if (i_cmd.log_start) begin
                r_tail <= tail_inc;
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.ev_pop) begin
                r_head <= head_inc;
                r_fill <= r_fill - 1'b1;
            end
            if (i_cmd.log_upd && hits_rdata == '0) begin
                r_active <= r_active + 1'b1;
            end
            if (i_cmd.ev_upd && hits_rdata == FW'(1) && r_active != '0) begin
                r_active <= r_active - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_q <= TW'(i_in.timestamp);
        end
        if (i_cmd.log_start) begin
            r_id <= SW'(i_in.source_id);
        end
        if (i_cmd.ev_pop) begin
            r_src <= head_src;
        end
        if (i_cmd.out_load) begin
            r_out.idle_sources  <= (sc_w > act_w) ? ID_W'(sc_w - act_w) : '0;
            r_out.overflow_seen <= r_overflow;
        end
    end

    assign o_status.clr_last   = (r_clr_cnt == SW'(MAX_SOURCES));
    assign o_status.id_ok      = (in_id_w != '0) && (in_id_w <= sc_w)
                                 && (in_id_w <= MW'(MAX_SOURCES));
    assign o_status.fifo_full  = (r_fill == FW'(FIFO_DEPTH));
    assign o_status.fifo_empty = (r_fill == '0);
    // evict only heads that are not in the future and lie outside the window
    assign o_status.evict      = (head_time <= r_q)
                                 && (CMP_W'(head_age) > CMP_W'(r_window));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> src/sliding_window_idle_source_count_top.sv
// Top level of the sliding window idle source counter.
//
//  Channel  Direction  Handshake                   Payload
//  in       request    i_in_valid / o_in_ready     i_in  (command, source_id, timestamp)
//  out      result     o_out_valid / i_out_ready   o_out (idle_sources, overflow_seen)
//  cfg      write      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A log does a count read-modify-write, writing back in S_LOG; an ignored or dropped
// log stays in idle. A query on an empty FIFO goes straight to the result; otherwise
// it reads the FIFO head, then evicts entries in turn, each by a head check and a count
// read-modify-write, until a head is kept or the FIFO is empty.
// After reset a clearing pass zeroes all MAX_SOURCES + 1 count entries; no request
// is taken meanwhile. A held result blocks the next query's hand-off, and input
// waits until that hand-off is done.
`timescale 1ns / 1ps

module sliding_window_idle_source_count_top #(
    parameter int MAX_SOURCES = swidc_pkg::MAX_SOURCES_DEF,
    parameter int FIFO_DEPTH  = swidc_pkg::FIFO_DEPTH_DEF,
    parameter int TIME_WIDTH  = swidc_pkg::TIME_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swidc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swidc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  swidc_pkg::t_in_item              i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output swidc_pkg::t_out_item             o_out
);
    import swidc_pkg::*;

    t_cmd    cmd;
    t_status status;

    swidc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_command(i_in.command),
        .o_in_ready  (o_in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    swidc_dp #(
        .MAX_SOURCES(MAX_SOURCES),
        .FIFO_DEPTH (FIFO_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

>>> src/swidc_chk.sv
// Port-level checker for the idle source counter, bound to the top level.
`timescale 1ns / 1ps

module swidc_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input swidc_pkg::t_in_item  i_in,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input swidc_pkg::t_out_item o_out
);
    import swidc_pkg::*;

    // reset starts the clearing pass: no request taken, no result shown
    a_reset_no_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken right after reset");

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // a query always occupies the block: a taken query leaves the input not ready
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.command == CMD_QUERY |=> !o_in_ready)
        else $error("request taken while a query is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

endmodule

bind sliding_window_idle_source_count_top swidc_chk u_swidc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);
